@@ src/tcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Travel calibration sequencer package
// Phase and motor command codes, register indexes and saturation limits
// shared by the sequencer and its checker.
// ----------------------------------------------------------------------------
package tcs_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_BOTTOM = 2'd1,
    PH_TOP    = 2'd2,
    PH_SPARE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_STOP = 2'd1,
    CMD_FWD  = 2'd2,
    CMD_BACK = 2'd3
  } cmd_t;

  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TRAVEL_W   = 24;
  localparam int unsigned STALL_W    = 17;

  localparam logic CFG_IDX_STEP_INTERVAL = 1'b0;
  localparam logic CFG_IDX_STALL_LIMIT   = 1'b1;

  localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST = 10'd2;
  localparam logic [LIMIT_W-1:0]    STALL_LIMIT_RST   = 16'd100;

  localparam logic [TRAVEL_W-1:0] TRAVEL_MAX = 24'hFF_FFFF;
  localparam logic [STALL_W-1:0]  STALL_MAX  = 17'h1_FFFF;

endpackage

@@ src/travel_calibration_sequencer.sv @@
// ----------------------------------------------------------------------------
// Travel calibration sequencer
// Drives a motor toward the bottom limit, then toward the top limit, while
// measuring the travel from the encoder and watching for a stalled motor.
// ----------------------------------------------------------------------------
// Usage: each input transfer is either a start (mode = 1) or an update carrying
// the current millisecond time, the encoder delta and both limit switches.
// Every input transfer yields exactly one result transfer with the motor
// command, the phase and the status flags after the item is applied.
// An input transfer lands in an input register; the update logic reads it
// with the sequencer state and writes the result register once that register
// is free, and the result is offered from the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the combinational state update between the input and result registers.
// When the receiver stalls, the result register holds its value and the input
// register still takes one more item; in_stall rises only when both are full.
// Reset clears both stages, returns the phase to idle, clears the counters and
// flags, and loads the default step interval and stall limit.
// Configuration writes are applied on the edge where cfg_we is high and must be
// made while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module travel_calibration_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [31:0]                     in_now_ms,
  input  logic signed [15:0]              in_encoder_delta,
  input  logic                            in_top_pressed,
  input  logic                            in_bottom_pressed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_motor_cmd,
  output logic [1:0]                      out_phase_now,
  output logic                            out_running,
  output logic                            out_finished,
  output logic                            out_failed,
  output logic [23:0]                     out_measured_steps
);

  logic [tcs_pkg::INTERVAL_W-1:0] step_interval_r;
  logic [tcs_pkg::LIMIT_W-1:0]    stall_limit_r;

  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [31:0] s1_now_r;
  logic [15:0] s1_delta_r;
  logic        s1_top_r;
  logic        s1_bottom_r;

  tcs_pkg::phase_t                phase_r, phase_nxt;
  logic [tcs_pkg::TRAVEL_W-1:0]   travel_r, travel_nxt;
  logic [tcs_pkg::STALL_W-1:0]    stall_r, stall_nxt;
  logic [31:0]                    last_step_r, last_step_nxt;
  logic                           done_r, done_nxt;
  logic                           fail_r, fail_nxt;
  tcs_pkg::cmd_t                  cmd_nxt;

  logic                           out_valid_r;
  tcs_pkg::cmd_t                  out_cmd_r;
  tcs_pkg::phase_t                out_phase_r;
  logic                           out_running_r;
  logic                           out_done_r;
  logic                           out_fail_r;
  logic [tcs_pkg::TRAVEL_W-1:0]   out_travel_r;

  logic                           adv;
  logic [tcs_pkg::STALL_W-1:0]    mag;
  logic [31:0]                    elapsed;
  logic                           active;
  logic                           due;
  logic [tcs_pkg::TRAVEL_W:0]     travel_sum;
  logic                           running_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  assign mag = s1_delta_r[15]
             ? (tcs_pkg::STALL_W'(17'h1_0000) - {1'b0, s1_delta_r})
             : {1'b0, s1_delta_r};
  assign elapsed    = s1_now_r - last_step_r;
  assign active     = (phase_r == tcs_pkg::PH_BOTTOM) || (phase_r == tcs_pkg::PH_TOP);
  assign due        = elapsed >= {22'd0, step_interval_r};
  assign travel_sum = {1'b0, travel_r} + {8'd0, mag};

  always_comb begin
    phase_nxt     = phase_r;
    travel_nxt    = travel_r;
    stall_nxt     = stall_r;
    last_step_nxt = last_step_r;
    done_nxt      = done_r;
    fail_nxt      = fail_r;
    cmd_nxt       = tcs_pkg::CMD_NONE;
    if (s1_mode_r) begin
      cmd_nxt       = tcs_pkg::CMD_STOP;
      phase_nxt     = tcs_pkg::PH_BOTTOM;
      travel_nxt    = '0;
      stall_nxt     = '0;
      last_step_nxt = '0;
      done_nxt      = 1'b0;
      fail_nxt      = 1'b0;
    end else if (active && due) begin
      last_step_nxt = s1_now_r;
      if (mag != '0) begin
        travel_nxt = travel_sum[tcs_pkg::TRAVEL_W] ? tcs_pkg::TRAVEL_MAX
                                                   : travel_sum[tcs_pkg::TRAVEL_W-1:0];
        stall_nxt  = '0;
      end
      if (phase_r == tcs_pkg::PH_BOTTOM) begin
        if (s1_bottom_r) begin
          cmd_nxt    = tcs_pkg::CMD_STOP;
          travel_nxt = '0;
          stall_nxt  = '0;
          phase_nxt  = tcs_pkg::PH_TOP;
        end else begin
          cmd_nxt = tcs_pkg::CMD_FWD;
          if (stall_nxt != tcs_pkg::STALL_MAX) begin
            stall_nxt = stall_nxt + tcs_pkg::STALL_W'(1);
          end
        end
      end else begin
        if (s1_top_r) begin
          cmd_nxt   = tcs_pkg::CMD_STOP;
          phase_nxt = tcs_pkg::PH_IDLE;
          done_nxt  = 1'b1;
        end else begin
          cmd_nxt = tcs_pkg::CMD_BACK;
          if (stall_nxt != tcs_pkg::STALL_MAX) begin
            stall_nxt = stall_nxt + tcs_pkg::STALL_W'(1);
          end
        end
      end
      if ((cmd_nxt != tcs_pkg::CMD_STOP) && (stall_nxt > {1'b0, stall_limit_r})) begin
        cmd_nxt   = tcs_pkg::CMD_STOP;
        phase_nxt = tcs_pkg::PH_IDLE;
        fail_nxt  = 1'b1;
      end
    end
  end

  assign running_nxt = (phase_nxt != tcs_pkg::PH_IDLE) && !done_nxt && !fail_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_interval_r <= tcs_pkg::STEP_INTERVAL_RST;
      stall_limit_r   <= tcs_pkg::STALL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tcs_pkg::CFG_IDX_STEP_INTERVAL: step_interval_r <= cfg_data[tcs_pkg::INTERVAL_W-1:0];
        tcs_pkg::CFG_IDX_STALL_LIMIT:   stall_limit_r   <= cfg_data[tcs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r   <= in_mode;
      s1_now_r    <= in_now_ms;
      s1_delta_r  <= in_encoder_delta;
      s1_top_r    <= in_top_pressed;
      s1_bottom_r <= in_bottom_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= tcs_pkg::PH_IDLE;
      travel_r    <= '0;
      stall_r     <= '0;
      last_step_r <= '0;
      done_r      <= 1'b0;
      fail_r      <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        phase_r     <= phase_nxt;
        travel_r    <= travel_nxt;
        stall_r     <= stall_nxt;
        last_step_r <= last_step_nxt;
        done_r      <= done_nxt;
        fail_r      <= fail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_cmd_r     <= cmd_nxt;
      out_phase_r   <= phase_nxt;
      out_running_r <= running_nxt;
      out_done_r    <= done_nxt;
      out_fail_r    <= fail_nxt;
      out_travel_r  <= travel_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_cmd      = out_cmd_r;
  assign out_phase_now      = out_phase_r;
  assign out_running        = out_running_r;
  assign out_finished       = out_done_r;
  assign out_failed         = out_fail_r;
  assign out_measured_steps = out_travel_r;

endmodule

@@ src/tcs_checker.sv @@
// ----------------------------------------------------------------------------
// Travel calibration sequencer checker
// Port-level properties of the sequencer, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module tcs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      out_motor_cmd,
  input logic [1:0]                      out_phase_now,
  input logic                            out_running,
  input logic                            out_finished,
  input logic                            out_failed,
  input logic [23:0]                     out_measured_steps
);

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result transfer dropped while stalled.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_finished && out_failed))
    else $error("Finished and failed both set.");

  a_running_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_finished || out_failed ||
                  out_phase_now == tcs_pkg::PH_IDLE) |-> !out_running)
    else $error("Running reported after the sequence ended.");

  a_step_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_motor_cmd == tcs_pkg::CMD_FWD) |->
      (out_phase_now == tcs_pkg::PH_BOTTOM) && out_running)
    else $error("Forward step outside the bottom-seeking phase.");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase_now == tcs_pkg::PH_BOTTOM) &&
      (out_motor_cmd == tcs_pkg::CMD_STOP) |-> (out_measured_steps == '0))
    else $error("Start result carries a nonzero travel count.");

endmodule

bind travel_calibration_sequencer tcs_checker u_tcs_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Travel calibration sequencer testbench
// Runs directed sequences and randomized calibration sessions through the
// sequencer with random idling on both channels. A cycle-free predictor
// computes the expected status of every input transfer, and each result
// transfer is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SHOW_LIMIT = 10;

  typedef struct packed {
    tcs_pkg::cmd_t                 cmd;
    tcs_pkg::phase_t               phase;
    logic                          running;
    logic                          finished;
    logic                          failed;
    logic [tcs_pkg::TRAVEL_W-1:0]  steps;
  } seq_status_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic                             cfg_index = 1'b0;
  logic [tcs_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic                             in_mode = 1'b0;
  logic [31:0]                      in_now_ms = '0;
  logic signed [15:0]               in_encoder_delta = '0;
  logic                             in_top_pressed = 1'b0;
  logic                             in_bottom_pressed = 1'b0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       out_motor_cmd;
  logic [1:0]                       out_phase_now;
  logic                             out_running;
  logic                             out_finished;
  logic                             out_failed;
  logic [23:0]                      out_measured_steps;

  logic [tcs_pkg::INTERVAL_W-1:0]   model_interval = tcs_pkg::STEP_INTERVAL_RST;
  logic [tcs_pkg::LIMIT_W-1:0]      model_limit = tcs_pkg::STALL_LIMIT_RST;
  tcs_pkg::phase_t                  model_phase = tcs_pkg::PH_IDLE;
  logic [tcs_pkg::TRAVEL_W-1:0]     model_travel = '0;
  logic [tcs_pkg::STALL_W-1:0]      model_stall = '0;
  logic [31:0]                      model_last = '0;
  logic                             model_done = 1'b0;
  logic                             model_fail = 1'b0;

  seq_status_t expected_status[$];

  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int runs_finished = 0;
  int runs_failed = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  travel_calibration_sequencer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_now_ms          (in_now_ms),
    .in_encoder_delta   (in_encoder_delta),
    .in_top_pressed     (in_top_pressed),
    .in_bottom_pressed  (in_bottom_pressed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_motor_cmd      (out_motor_cmd),
    .out_phase_now      (out_phase_now),
    .out_running        (out_running),
    .out_finished       (out_finished),
    .out_failed         (out_failed),
    .out_measured_steps (out_measured_steps)
  );

  always #4 clk = ~clk;

  function automatic seq_status_t apply_sequencer_item(input logic mode,
                                                       input logic [31:0] now,
                                                       input logic signed [15:0] delta,
                                                       input logic top,
                                                       input logic bottom);
    logic [16:0]                 mag;
    logic [tcs_pkg::TRAVEL_W:0]  sum;
    logic [31:0]                 elapsed;
    logic                        check_stall;
    seq_status_t                 st;
    mag = delta[15] ? 17'h1_0000 - {1'b0, delta} : {1'b0, delta};
    elapsed = now - model_last;
    st.cmd = tcs_pkg::CMD_NONE;
    if (mode) begin
      st.cmd = tcs_pkg::CMD_STOP;
      model_phase = tcs_pkg::PH_BOTTOM;
      model_travel = '0;
      model_stall = '0;
      model_last = '0;
      model_done = 1'b0;
      model_fail = 1'b0;
    end else if ((model_phase == tcs_pkg::PH_BOTTOM || model_phase == tcs_pkg::PH_TOP) &&
                 elapsed >= 32'(model_interval)) begin
      check_stall = 1'b1;
      model_last = now;
      if (mag != '0) begin
        sum = {1'b0, model_travel} + {8'd0, mag};
        model_travel = (sum > {1'b0, tcs_pkg::TRAVEL_MAX}) ? tcs_pkg::TRAVEL_MAX
                                                           : sum[tcs_pkg::TRAVEL_W-1:0];
        model_stall = '0;
      end
      if (model_phase == tcs_pkg::PH_BOTTOM) begin
        if (bottom) begin
          st.cmd = tcs_pkg::CMD_STOP;
          model_travel = '0;
          model_stall = '0;
          model_phase = tcs_pkg::PH_TOP;
          check_stall = 1'b0;
        end else begin
          st.cmd = tcs_pkg::CMD_FWD;
          if (model_stall < tcs_pkg::STALL_MAX)
            model_stall = model_stall + tcs_pkg::STALL_W'(1);
        end
      end else begin
        if (top) begin
          st.cmd = tcs_pkg::CMD_STOP;
          model_phase = tcs_pkg::PH_IDLE;
          model_done = 1'b1;
          check_stall = 1'b0;
          runs_finished++;
        end else begin
          st.cmd = tcs_pkg::CMD_BACK;
          if (model_stall < tcs_pkg::STALL_MAX)
            model_stall = model_stall + tcs_pkg::STALL_W'(1);
        end
      end
      if (check_stall && model_stall > {1'b0, model_limit}) begin
        st.cmd = tcs_pkg::CMD_STOP;
        model_phase = tcs_pkg::PH_IDLE;
        model_fail = 1'b1;
        runs_failed++;
      end
    end
    st.phase = model_phase;
    st.running = (model_phase != tcs_pkg::PH_IDLE) && !model_done && !model_fail;
    st.finished = model_done;
    st.failed = model_fail;
    st.steps = model_travel;
    return st;
  endfunction

  task automatic send_item(input logic mode, input logic [31:0] now,
                           input logic signed [15:0] delta, input logic top,
                           input logic bottom);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_now_ms <= now;
    in_encoder_delta <= delta;
    in_top_pressed <= top;
    in_bottom_pressed <= bottom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_status.push_back(apply_sequencer_item(mode, now, delta, top, bottom));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx,
                                input logic [tcs_pkg::CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == tcs_pkg::CFG_IDX_STEP_INTERVAL) model_interval = data[tcs_pkg::INTERVAL_W-1:0];
    else model_limit = data[tcs_pkg::LIMIT_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [tcs_pkg::INTERVAL_W-1:0] interval,
                           input logic [tcs_pkg::LIMIT_W-1:0] limit);
    write_register(tcs_pkg::CFG_IDX_STEP_INTERVAL, {6'($urandom), interval});
    write_register(tcs_pkg::CFG_IDX_STALL_LIMIT, limit);
  endtask

  task automatic test_update_sequence();
    send_item(1'b0, 32'd100, 16'sd5, 1'b1, 1'b1);
    send_item(1'b1, 32'hFFFF_FFFF, -16'sd1, 1'b1, 1'b1);
    send_item(1'b0, 32'd1, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd2, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd3, 16'sd9, 1'b0, 1'b0);
    send_item(1'b0, 32'd4, 16'sh7FFF, 1'b1, 1'b0);
    send_item(1'b0, 32'd6, 16'sh8000, 1'b0, 1'b0);
    send_item(1'b0, 32'd8, 16'sd4, 1'b1, 1'b1);
    send_item(1'b0, 32'd10, 16'sd7, 1'b0, 1'b1);
    send_item(1'b0, 32'd12, -16'sd3, 1'b1, 1'b0);
    send_item(1'b0, 32'd20, 16'sd2, 1'b1, 1'b1);
    send_item(1'b1, 32'd21, 16'sd0, 1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    configure(10'd0, 16'd0);
    send_item(1'b1, 32'd0, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd0, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd5, 16'sd3, 1'b0, 1'b0);
    send_item(1'b1, 32'd5, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd5, 16'sd0, 1'b0, 1'b1);
    send_item(1'b0, 32'd5, 16'sd1, 1'b1, 1'b0);
    configure(10'd1023, 16'hFFFF);
    send_item(1'b1, 32'd0, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd1022, 16'sd1, 1'b0, 1'b0);
    send_item(1'b0, 32'd1023, 16'sd1, 1'b0, 1'b0);
    send_item(1'b0, 32'd2045, 16'sd1, 1'b0, 1'b0);
    send_item(1'b0, 32'd2046, 16'sd0, 1'b0, 1'b0);
    configure(10'd1, 16'd1);
    send_item(1'b1, 32'd0, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'hFFFF_FFFE, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'hFFFF_FFFF, 16'sd2, 1'b0, 1'b0);
    send_item(1'b0, 32'h0000_0000, -16'sd1, 1'b0, 1'b0);
    send_item(1'b0, 32'h0000_0000, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'h0000_0001, 16'sd0, 1'b0, 1'b0);
    configure(10'd1000, 16'd1);
    send_item(1'b1, 32'd0, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd1000, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd1999, 16'sd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd2000, 16'sd0, 1'b0, 1'b0);
  endtask

  task automatic test_random_sessions(input int n_items);
    int                              target;
    int                              len;
    int                              pick;
    logic [31:0]                     clock_ms;
    logic signed [15:0]              delta;
    logic                            restart;
    logic [tcs_pkg::INTERVAL_W-1:0]  interval;
    logic [tcs_pkg::LIMIT_W-1:0]     limit;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(4, 0);
      case (pick)
        0: interval = 10'd0;
        1: interval = 10'd1;
        2: interval = 10'd1023;
        default: interval = 10'($urandom_range(1000, 1));
      endcase
      pick = $urandom_range(5, 0);
      case (pick)
        0: limit = 16'd0;
        1: limit = 16'hFFFF;
        2, 3: limit = 16'($urandom_range(8, 1));
        default: limit = 16'($urandom);
      endcase
      configure(interval, limit);
      clock_ms = $urandom;
      len = $urandom_range(40, 10);
      send_item(1'b1, $urandom, 16'($urandom), 1'($urandom), 1'($urandom));
      for (int i = 0; i < len; i++) begin
        if (i == len / 2) drain_results();
        pick = $urandom_range(99, 0);
        if (pick < 75) clock_ms = clock_ms + $urandom_range(2 * interval + 1, 0);
        else if (pick < 90) clock_ms = clock_ms + 32'(interval) - 1;
        else clock_ms = $urandom;
        pick = $urandom_range(99, 0);
        if (pick < 45) delta = '0;
        else if (pick < 85) delta = 16'($signed($urandom_range(64, 0)) - 32);
        else delta = 16'($urandom);
        if (model_phase == tcs_pkg::PH_IDLE) restart = ($urandom_range(1, 0) == 0);
        else restart = ($urandom_range(99, 0) < 4);
        send_item(restart, clock_ms, delta, ($urandom_range(99, 0) < 10),
                  ($urandom_range(99, 0) < 12));
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99, 0) < recv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    seq_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        error_count++;
        if (error_count <= SHOW_LIMIT)
          $display("%0t: unexpected result cmd=%0d phase=%0d run=%b fin=%b fail=%b steps=%0d",
                   $realtime, out_motor_cmd, out_phase_now, out_running, out_finished,
                   out_failed, out_measured_steps);
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        if (out_motor_cmd !== want.cmd || out_phase_now !== want.phase ||
            out_running !== want.running || out_finished !== want.finished ||
            out_failed !== want.failed || out_measured_steps !== want.steps) begin
          error_count++;
          if (error_count <= SHOW_LIMIT)
            $display({"%0t: result %0d expected cmd=%0d phase=%0d run=%b fin=%b fail=%b",
                      " steps=%0d, got cmd=%0d phase=%0d run=%b fin=%b fail=%b steps=%0d"},
                     $realtime, results_checked, want.cmd, want.phase, want.running,
                     want.finished, want.failed, want.steps, out_motor_cmd, out_phase_now,
                     out_running, out_finished, out_failed, out_measured_steps);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 36;
    recv_idle_pct = 49;
    test_update_sequence();
    test_register_extremes();
    test_random_sessions(115);
    send_idle_pct = 49;
    recv_idle_pct = 36;
    test_random_sessions(115);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sessions(115);
    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d results from %0d input transfers across %0d register writes.",
             results_checked, items_sent, cfg_writes);
    $display("Calibrations finished: %0d, stall aborts: %0d, mismatches: %0d.",
             runs_finished, runs_failed, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tcs_pkg.sv
src/travel_calibration_sequencer.sv
src/tcs_checker.sv
tb/testbench.sv
